[design/rmf_pkg.sv]
// Package for the running median filter: widths, beat types and controller states.
`timescale 1ns / 1ps

package rmf_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_WINDOW  = 32;
    localparam int CFG_BITS    = 6;

    localparam logic [CFG_BITS-1:0] WINDOW_LENGTH_RESET = CFG_BITS'(3);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        t_sample sample;
        logic    last;
    } t_in_beat;

    typedef struct packed {
        t_sample median;
        logic    last_out;
    } t_out_beat;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_RUN,
        S_PICK
    } t_state;

endpackage

[design/rmf_cell.sv]
// One cell of the sample chain: history tap, scan register and rank counter.
`timescale 1ns / 1ps

module rmf_cell #(
    parameter int MAX_WINDOW = rmf_pkg::MAX_WINDOW,
    parameter int IDX        = 0,
    localparam int W         = $clog2(MAX_WINDOW + 1),
    localparam int IW        = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
    input  logic             i_clk,
    input  logic             i_shift,
    input  rmf_pkg::t_sample i_shift_in,
    output rmf_pkg::t_sample o_sample,
    input  logic             i_load,
    input  logic             i_run,
    input  rmf_pkg::t_sample i_scan_in,
    output rmf_pkg::t_sample o_scan,
    input  rmf_pkg::t_sample i_token,
    input  logic [IW-1:0]    i_token_idx,
    input  logic [W-1:0]     i_n,
    input  logic [IW-1:0]    i_k,
    output rmf_pkg::t_sample o_pick
);

    rmf_pkg::t_sample r_sample;
    rmf_pkg::t_sample r_scan;
    logic [IW-1:0]    r_rank;
    logic             w_below;
    logic             w_hit;

    // Ties are broken by position so that every rank is held by exactly one cell.
    assign w_below = (i_token < r_sample) ||
                     ((i_token == r_sample) && (i_token_idx < IW'(IDX)));

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_sample <= i_shift_in;
        end
        if (i_load) begin
            r_scan <= r_sample;
            r_rank <= '0;
        end else if (i_run) begin
            r_scan <= i_scan_in;
            if (w_below) begin
                r_rank <= r_rank + IW'(1);
            end
        end
    end

    assign w_hit    = (W'(IDX) < i_n) && (r_rank == i_k);
    assign o_pick   = w_hit ? r_sample : '0;
    assign o_sample = r_sample;
    assign o_scan   = r_scan;

endmodule

[design/running_median_filter.sv]
// Top level of the running median filter: controller, cell chain and output register.
`timescale 1ns / 1ps

// Running median filter over a stream of signed samples.
// Input beats carry a sample and a last flag on i_in_beat; a beat is taken at a
// rising edge where i_in_valid is high and o_in_stall is low. Result beats carry
// the median and last_out on o_out_beat and leave when o_out_valid is high and
// i_out_stall is low. The window length register is written through
// i_cfg_wr_en / i_cfg_wr_data; a write ends the current signal.
// A chain of MAX_WINDOW cells holds the newest samples, newest in cell 0. For
// each result the controller first loads the scan registers, then streams
// every window sample past all cells so that each cell counts its rank, and
// then picks the cell whose rank is the median index into the output register.
// A sample marked last produces up to window/2+1 results, one after another,
// each with its own window size.
// The input is stalled while a result is being worked out; it is taken again
// as soon as the last result of the item sits in the output register, even if
// the receiver still stalls it. A stalled receiver holds the result and only
// delays the next pick. After reset the window length is 3 and no signal is
// open; the history holds nothing valid until samples arrive.

module running_median_filter #(
    parameter int MAX_WINDOW = rmf_pkg::MAX_WINDOW
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  rmf_pkg::t_in_beat              i_in_beat,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output rmf_pkg::t_out_beat             o_out_beat,
    input  logic                           i_cfg_wr_en,
    input  logic [rmf_pkg::CFG_BITS-1:0]   i_cfg_wr_data
);

    // W holds a count up to MAX_WINDOW, IW a cell position, CW the length math.
    localparam int W  = $clog2(MAX_WINDOW + 1);
    localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW = (W > rmf_pkg::CFG_BITS) ? W : rmf_pkg::CFG_BITS;

    rmf_pkg::t_state               r_state;
    rmf_pkg::t_state               n_state;
    logic [rmf_pkg::CFG_BITS-1:0]  r_wl;
    logic [W-1:0]                  r_seen;
    logic [CW-1:0]                 r_d;
    logic                          r_last_job;
    logic [W-1:0]                  r_n;
    logic [IW-1:0]                 r_step;
    logic                          r_out_valid;
    rmf_pkg::t_out_beat            r_out_beat;

    logic                          w_in_acc;
    logic                          w_slot_free;
    logic                          w_cell_load;
    logic                          w_cell_run;
    logic                          w_pick_fire;
    logic                          w_run_done;
    logic                          w_more;

    logic [CW-1:0]                 w_len;
    logic [CW-1:0]                 w_wl_ext;
    logic [CW-1:0]                 w_ahead;
    logic [CW-1:0]                 w_back;
    logic [W-1:0]                  w_seen_next;
    logic [CW-1:0]                 w_seen_next_c;
    logic                          w_has_out;
    logic [CW-1:0]                 w_d_init;
    logic [CW-1:0]                 w_n_calc;
    logic [CW-1:0]                 w_n_min;
    logic [IW-1:0]                 w_k;
    rmf_pkg::t_sample              w_median;

    rmf_pkg::t_sample              w_sample [MAX_WINDOW];
    rmf_pkg::t_sample              w_scan   [MAX_WINDOW];
    rmf_pkg::t_sample              w_pick   [MAX_WINDOW];

    // Effective window: a length of zero acts as one, anything above the chain
    // length acts as the chain length. Even lengths look one sample further ahead.
    assign w_wl_ext = CW'(r_wl);
    assign w_len    = (w_wl_ext == '0) ? CW'(1) :
                      ((w_wl_ext > CW'(MAX_WINDOW)) ? CW'(MAX_WINDOW) : w_wl_ext);
    assign w_ahead  = w_len >> 1;
    assign w_back   = w_len - w_ahead - CW'(1);

    assign w_in_acc    = i_in_valid && (r_state == rmf_pkg::S_IDLE);
    assign w_slot_free = !r_out_valid || !i_out_stall;

    // Sample count of the open signal saturates at the chain length.
    assign w_seen_next   = (r_seen < W'(MAX_WINDOW)) ? (r_seen + W'(1)) : r_seen;
    assign w_seen_next_c = CW'(w_seen_next);

    // A plain sample yields a result once the look-ahead is filled; a last
    // sample always yields at least one, starting from the oldest pending one.
    assign w_has_out = i_in_beat.last || (w_seen_next_c > w_ahead);
    assign w_d_init  = (i_in_beat.last && ((w_seen_next_c - CW'(1)) < w_ahead)) ?
                       (w_seen_next_c - CW'(1)) : w_ahead;

    // Window size of the result d positions behind the newest sample.
    assign w_n_calc = r_d + w_back + CW'(1);
    assign w_n_min  = (w_n_calc < CW'(r_seen)) ? w_n_calc : CW'(r_seen);
    assign w_k      = IW'(r_n >> 1);

    assign w_run_done = (W'(r_step) == (r_n - W'(1)));
    assign w_more     = r_last_job && (r_d != '0);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            rmf_pkg::S_IDLE: begin
                if (w_in_acc && w_has_out) begin
                    n_state = rmf_pkg::S_LOAD;
                end
            end
            rmf_pkg::S_LOAD: begin
                n_state = rmf_pkg::S_RUN;
            end
            rmf_pkg::S_RUN: begin
                if (w_run_done) begin
                    n_state = rmf_pkg::S_PICK;
                end
            end
            rmf_pkg::S_PICK: begin
                if (w_slot_free) begin
                    n_state = w_more ? rmf_pkg::S_LOAD : rmf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rmf_pkg::S_IDLE;
            end
        endcase
    end

    // Controller outputs.
    always_comb begin
        o_in_stall  = 1'b1;
        w_cell_load = 1'b0;
        w_cell_run  = 1'b0;
        w_pick_fire = 1'b0;
        case (r_state)
            rmf_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
            end
            rmf_pkg::S_LOAD: begin
                w_cell_load = 1'b1;
            end
            rmf_pkg::S_RUN: begin
                w_cell_run = 1'b1;
            end
            rmf_pkg::S_PICK: begin
                w_pick_fire = w_slot_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rmf_pkg::S_IDLE;
            r_wl        <= rmf_pkg::WINDOW_LENGTH_RESET;
            r_seen      <= '0;
            r_out_valid <= 1'b0;
            r_last_job  <= 1'b0;
            r_d         <= '0;
            r_n         <= '0;
            r_step      <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_wr_en) begin
                r_wl   <= i_cfg_wr_data;
                r_seen <= '0;
            end

            // The sample count of a closing signal is kept through its flush,
            // since every flushed window is cut by it; the final pick clears it.
            if (w_in_acc) begin
                r_seen     <= w_seen_next;
                r_d        <= w_d_init;
                r_last_job <= i_in_beat.last;
            end

            if (w_cell_load) begin
                r_n    <= w_n_min[W-1:0];
                r_step <= '0;
            end else if (w_cell_run) begin
                r_step <= r_step + IW'(1);
            end

            if (w_pick_fire) begin
                r_out_valid <= 1'b1;
                if (w_more) begin
                    r_d <= r_d - CW'(1);
                end else if (r_last_job) begin
                    r_seen <= '0;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (w_pick_fire) begin
            r_out_beat.median   <= w_median;
            r_out_beat.last_out <= r_last_job && (r_d == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    // Exactly one window cell holds the median rank, so the picks merge by OR.
    always_comb begin
        w_median = '0;
        for (int i = 0; i < MAX_WINDOW; i++) begin
            w_median = w_median | w_pick[i];
        end
    end

    // The cell chain. Samples shift away from cell 0 on every accepted beat;
    // during a scan the copies shift toward cell 0, which feeds the token.
    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        rmf_pkg::t_sample w_shift_in;
        rmf_pkg::t_sample w_scan_in;

        if (g == 0) begin : g_head
            assign w_shift_in = i_in_beat.sample;
        end else begin : g_body
            assign w_shift_in = w_sample[g-1];
        end

        if (g == MAX_WINDOW - 1) begin : g_tail
            assign w_scan_in = '0;
        end else begin : g_link
            assign w_scan_in = w_scan[g+1];
        end

        rmf_cell #(
            .MAX_WINDOW (MAX_WINDOW),
            .IDX        (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_shift     (w_in_acc),
            .i_shift_in  (w_shift_in),
            .o_sample    (w_sample[g]),
            .i_load      (w_cell_load),
            .i_run       (w_cell_run),
            .i_scan_in   (w_scan_in),
            .o_scan      (w_scan[g]),
            .i_token     (w_scan[0]),
            .i_token_idx (r_step),
            .i_n         (r_n),
            .i_k         (w_k),
            .o_pick      (w_pick[g])
        );
    end

endmodule

[tb/running_median_filter_tb.sv]
// Self-checking testbench for the running median filter: directed and random sample streams.
`timescale 1ns / 1ps

module running_median_filter_tb;
    import rmf_pkg::*;

    // After the last expected beat, the wait of SETTLE_CYCLES covers any sample that
    // is still being worked on but can produce no result.
    localparam int SETTLE_CYCLES = MAX_WINDOW + 8;
    localparam int HOLD_OFF_LEN  = 150;
    localparam int MAX_SIGNAL    = 40;

    localparam t_sample SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam t_sample SAMPLE_MIN = ~SAMPLE_MAX;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                in_valid      = 1'b0;
    logic                out_stall     = 1'b0;
    logic                cfg_wr_en     = 1'b0;
    logic [CFG_BITS-1:0] cfg_wr_data   = '0;
    t_in_beat            in_beat       = '0;
    logic                in_stall;
    logic                out_valid;
    t_out_beat           out_beat;

    // Mirror of the filter: the samples of the open signal, newest first, capped
    // at MAX_WINDOW, and the window length in effect after clamping.
    t_sample   signal_history[$];
    int        window_len = WINDOW_LENGTH_RESET;
    t_out_beat expected_medians[$];

    // Knobs shared by the stimulus and the receiver process.
    bit sender_gaps_on     = 1'b1;
    bit receiver_stalls_on = 1'b1;
    bit hold_off_req       = 1'b0;

    int errors          = 0;
    int samples_sent    = 0;
    int signals_closed  = 0;
    int settings_written = 0;
    int results_checked = 0;

    running_median_filter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_in_beat     (in_beat),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_beat    (out_beat),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    always #5 i_clk = ~i_clk;

    // Median of the newest span+1 samples of the open signal, or of all of them
    // when the signal is shorter. The window is sorted ascending and the element
    // at index count/2 is taken, which gives the upper median for even counts.
    function automatic t_sample window_median(input int span);
        t_sample sorted[MAX_WINDOW];
        t_sample v;
        int      n;
        int      a;
        int      j;
        n = (span + 1 < signal_history.size()) ? span + 1 : signal_history.size();
        for (a = 0; a < n; a++) begin
            v = signal_history[a];
            j = a;
            while (j > 0 && sorted[j-1] > v) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = v;
        end
        return sorted[n/2];
    endfunction

    task automatic queue_median(input t_sample m, input logic fin);
        t_out_beat b;
        b.median   = m;
        b.last_out = fin;
        expected_medians.push_back(b);
    endtask

    // Works out every result beat that one accepted sample causes.
    task automatic predict_medians(input t_sample s, input logic is_last);
        int ahead;
        int back;
        int dmax;
        int d;
        ahead = window_len / 2;
        back  = window_len - 1 - ahead;
        signal_history.push_front(s);
        if (signal_history.size() > MAX_WINDOW) begin
            void'(signal_history.pop_back());
        end
        if (!is_last) begin
            // The output for the sample ahead positions back becomes known as soon
            // as enough look-ahead has arrived.
            if (signal_history.size() > ahead) begin
                queue_median(window_median(ahead + back), 1'b0);
            end
        end else begin
            // Flush every pending position; windows shrink toward the end of the
            // signal, and the last beat carries last_out.
            dmax = signal_history.size() - 1;
            if (dmax > ahead) begin
                dmax = ahead;
            end
            for (d = dmax; d >= 0; d--) begin
                queue_median(window_median(d + back), d == 0);
            end
            signal_history.delete();
        end
    endtask

    // Receiver: random stall bursts, plus a long hold-off that a test requests by
    // toggling hold_off_req. The hold-off is counted here so the sender keeps
    // offering beats while the filter backs up.
    always @(negedge i_clk) begin
        static bit hold_off_ack = 1'b0;
        static int hold_left    = 0;
        static int stall_left   = 0;
        if (hold_off_req != hold_off_ack) begin
            hold_off_ack = hold_off_req;
            hold_left    = HOLD_OFF_LEN;
        end
        if (hold_left > 0) begin
            out_stall = 1'b1;
            hold_left--;
        end else if (stall_left > 0) begin
            out_stall = 1'b1;
            stall_left--;
        end else if (receiver_stalls_on && $urandom_range(0, 5) == 0) begin
            out_stall  = 1'b1;
            stall_left = $urandom_range(0, 6);
        end else begin
            out_stall = 1'b0;
        end
    end

    // Every result beat that leaves the filter is matched against the oldest
    // expected median, field by field.
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (expected_medians.size() == 0) begin
                $error("unexpected result beat: median %0d, last_out %0b",
                       out_beat.median, out_beat.last_out);
                errors++;
            end else begin
                want = expected_medians.pop_front();
                results_checked++;
                if (out_beat.median !== want.median) begin
                    $error("median: expected %0d, actual %0d", want.median, out_beat.median);
                    errors++;
                end
                if (out_beat.last_out !== want.last_out) begin
                    $error("last_out: expected %0b, actual %0b",
                           want.last_out, out_beat.last_out);
                    errors++;
                end
            end
        end
    end

    // Offers one sample beat and returns at the edge where it is accepted. Valid
    // stays high afterwards so back-to-back calls stream without a bubble; the
    // caller lowers it through wait_for_results before doing anything else.
    task automatic send_sample(input t_sample s, input logic is_last);
        @(negedge i_clk);
        if (sender_gaps_on && $urandom_range(0, 4) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        in_beat.sample = s;
        in_beat.last   = is_last;
        in_valid       = 1'b1;
        do @(posedge i_clk); while (in_stall);
        predict_medians(s, is_last);
        samples_sent++;
        if (is_last) begin
            signals_closed++;
        end
    endtask

    // Stops the sender and waits until the filter has delivered everything owed
    // and has had time to finish any sample that produces no result.
    task automatic wait_for_results();
        @(negedge i_clk);
        in_valid = 1'b0;
        while (expected_medians.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The register is only written with the filter idle. A write ends the open
    // signal, so pending positions are dropped from the mirror as well.
    task automatic write_window_length(input logic [CFG_BITS-1:0] v);
        wait_for_results();
        @(negedge i_clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge i_clk);
        cfg_wr_en = 1'b0;
        if (v == 0) begin
            window_len = 1;
        end else if (v > MAX_WINDOW) begin
            window_len = MAX_WINDOW;
        end else begin
            window_len = v;
        end
        signal_history.delete();
        settings_written++;
    endtask

    // Mostly full-range values, with extremes and a narrow band that makes
    // duplicate samples common.
    function automatic t_sample pick_sample();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
            1, 2, 3: return t_sample'(int'($urandom_range(0, 8)) - 4);
            default: return t_sample'($urandom);
        endcase
    endfunction

    // Window lengths are mostly short to keep the run quick; the longest length
    // and the out-of-range codes show up now and then.
    function automatic logic [CFG_BITS-1:0] pick_window_length();
        case ($urandom_range(0, 9))
            0:       return CFG_BITS'(MAX_WINDOW);
            1:       return $urandom_range(0, 1) ? '0 : CFG_BITS'($urandom_range(33, 63));
            default: return CFG_BITS'($urandom_range(1, 9));
        endcase
    endfunction

    task automatic send_signal(input int n, input bit close);
        int i;
        for (i = 0; i < n; i++) begin
            send_sample(pick_sample(), close && (i == n - 1));
        end
    endtask

    // Reset length of 3: full-scale extremes in one signal, then a signal of a
    // single sample that is also its last.
    task automatic test_default_window();
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(0, 1'b0);
        send_sample(-1, 1'b0);
        send_sample(5, 1'b1);
        send_sample(7, 1'b1);
        wait_for_results();
    endtask

    // Length 1 passes samples through, an even length takes the upper median, a
    // length-32 signal shorter than its look-ahead only yields results on its
    // last beat, and the codes 0 and 63 are clamped.
    task automatic test_window_extremes();
        write_window_length(1);
        send_sample(3, 1'b0);
        send_sample(-3, 1'b1);
        write_window_length(4);
        send_sample(10, 1'b0);
        send_sample(40, 1'b0);
        send_sample(20, 1'b0);
        send_sample(30, 1'b1);
        write_window_length(32);
        send_sample(-2, 1'b0);
        send_sample(9, 1'b0);
        send_sample(-7, 1'b0);
        send_sample(4, 1'b0);
        send_sample(1, 1'b1);
        write_window_length(0);
        send_sample(100, 1'b0);
        send_sample(-100, 1'b1);
        write_window_length(63);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
        wait_for_results();
    endtask

    // A register write in the middle of a signal drops its pending outputs; the
    // next sample opens a fresh signal.
    task automatic test_write_mid_signal();
        write_window_length(5);
        send_sample(11, 1'b0);
        send_sample(-22, 1'b0);
        send_sample(33, 1'b0);
        write_window_length(5);
        send_sample(-44, 1'b0);
        send_sample(55, 1'b1);
        wait_for_results();
    endtask

    // The receiver holds off for a long stretch while samples keep coming, so the
    // filter fills and stalls its input. Then the sender pauses until every
    // result is in and resumes the same signal.
    task automatic test_backpressure();
        write_window_length(5);
        hold_off_req = ~hold_off_req;
        send_signal(20, 1'b0);
        wait_for_results();
        send_signal(10, 1'b1);
        wait_for_results();
    endtask

    // Groups of well-formed signals under random window lengths. Some groups end
    // with a signal that never sees its last beat and is cut by the next write.
    task automatic test_random_signals(input int budget);
        int sent;
        int n;
        int signals;
        int k;
        bit close;
        sent = 0;
        while (sent < budget) begin
            write_window_length(pick_window_length());
            signals = $urandom_range(2, 5);
            for (k = 0; k < signals && sent < budget; k++) begin
                n = $urandom_range(1, 2 * window_len + 3);
                if (n > MAX_SIGNAL) begin
                    n = MAX_SIGNAL;
                end
                close = (k < signals - 1) || ($urandom_range(0, 3) != 0);
                send_signal(n, close);
                sent += n;
            end
        end
        wait_for_results();
    endtask

    // Closing stretch with no gaps and no stalls on either side.
    task automatic test_steady_stream();
        sender_gaps_on     = 1'b0;
        receiver_stalls_on = 1'b0;
        write_window_length(7);
        send_signal(12, 1'b1);
        send_signal(13, 1'b1);
        wait_for_results();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_default_window();
        test_window_extremes();
        test_write_mid_signal();
        test_backpressure();
        test_random_signals(240);
        test_steady_stream();

        $display("Sent %0d samples in %0d closed signals over %0d window settings; %0d medians checked.",
                 samples_sent, signals_closed, settings_written, results_checked);
        $display("Covered clamped lengths 0 and 63, a long receiver hold-off and a gap-free stream.");
        if (errors == 0 && expected_medians.size() == 0) begin
            $display("running_median_filter_tb: clean");
        end else begin
            if (expected_medians.size() != 0) begin
                $error("%0d expected medians never arrived", expected_medians.size());
            end
            $display("running_median_filter_tb: errors");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("running_median_filter_tb: errors");
        $finish;
    end

endmodule
